>>> rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 decoder package
// Shared types, character constants and the character-to-sextet mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [5:0]  sextet_value_type;
   typedef logic [17:0] acc_type;
   typedef logic [23:0] group_type;
   typedef logic [1:0]  nbytes_type;

   // Characters of the base64 alphabet: the bounds of the letter and digit ranges, '+' and '/'.
   localparam byte_type CharUpperA = 8'h41;
   localparam byte_type CharUpperZ = 8'h5a;
   localparam byte_type CharLowerA = 8'h61;
   localparam byte_type CharLowerZ = 8'h7a;
   localparam byte_type CharDigit0 = 8'h30;
   localparam byte_type CharDigit9 = 8'h39;
   localparam byte_type CharPlus   = 8'h2b;
   localparam byte_type CharSlash  = 8'h2f;

   // Offsets that move each character range onto its sextet range (mod 256).
   localparam byte_type UpperOffset = 8'h41;  // 'A' -> 0
   localparam byte_type LowerOffset = 8'h47;  // 'a' -> 26
   localparam byte_type DigitOffset = 8'hfc;  // '0' -> 52
   localparam sextet_value_type SextetPlus  = 6'd62;
   localparam sextet_value_type SextetSlash = 6'd63;

   // Entries in the queue between the front and the back.
   localparam int unsigned QueueDepthDefault = 4;

   typedef struct packed {
      logic             valid;
      sextet_value_type value;
   } sextet_type;

   // One decoded group waiting to be sent out byte by byte.
   typedef struct packed {
      group_type  word;     // first byte in the top eight bits
      nbytes_type nbytes;   // 1 to 3 bytes
      logic       msg_end;  // the group closes the message
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } queue_wr_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

   function automatic sextet_type map_char(input byte_type c);
      sextet_type s;
      byte_type   diff;
      s    = '0;
      diff = '0;
      if (c >= CharUpperA && c <= CharUpperZ) begin
         diff    = c - UpperOffset;
         s.valid = 1'b1;
         s.value = diff[5:0];
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
         diff    = c - LowerOffset;
         s.valid = 1'b1;
         s.value = diff[5:0];
      end else if (c >= CharDigit0 && c <= CharDigit9) begin
         diff    = c - DigitOffset;
         s.valid = 1'b1;
         s.value = diff[5:0];
      end else if (c == CharPlus) begin
         s.valid = 1'b1;
         s.value = SextetPlus;
      end else if (c == CharSlash) begin
         s.valid = 1'b1;
         s.value = SextetSlash;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

>>> rtl/b64d_if.sv
// ----------------------------------------------------------------------------
// Base64 decoder channel interfaces
// Valid/ready channels for encoded characters and for decoded bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64d_req_if;
   logic               valid;
   logic               ready;
   b64d_pkg::byte_type enc_char;
   logic               msg_last;

   modport source (output valid, output enc_char, output msg_last, input ready);
   modport sink   (input valid, input enc_char, input msg_last, output ready);
endinterface

interface b64d_rsp_if;
   logic               valid;
   logic               ready;
   b64d_pkg::byte_type data_byte;
   logic               run_last;
   logic               msg_end;

   modport source (output valid, output data_byte, output run_last, output msg_end,
                   input ready);
   modport sink   (input valid, input data_byte, input run_last, input msg_end,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// Base64 decoder front
// Accepts characters, gathers sextets and hands finished groups to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   b64d_req_if.sink                   req,
   input  wire logic                  queue_space,
   output b64d_pkg::queue_wr_type     queue_wr
);
   import b64d_pkg::*;

   acc_type    acc_ff, acc_in;
   logic [1:0] cnt_ff, cnt_in;
   sextet_type sx;
   group_type  word;
   nbytes_type nbytes;
   logic       accept;

   assign req.ready = queue_space;
   assign accept    = req.valid && queue_space;

   always_comb begin
      sx     = map_char(req.enc_char);
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      word   = '0;
      nbytes = '0;
      if (accept && sx.valid) begin
         if (cnt_ff == 2'd3) begin
            word   = {acc_ff, sx.value};
            nbytes = 2'd3;
            acc_in = '0;
            cnt_in = '0;
         end else begin
            acc_in = {acc_ff[11:0], sx.value};
            cnt_in = cnt_ff + 2'd1;
         end
      end
      if (accept && req.msg_last) begin
         // Missing sextets of a short final group count as zero.
         if (nbytes == 2'd0 && cnt_in == 2'd3) begin
            word   = {acc_in, 6'd0};
            nbytes = 2'd2;
         end else if (nbytes == 2'd0 && cnt_in == 2'd2) begin
            word   = {acc_in[11:0], 12'd0};
            nbytes = 2'd1;
         end
         acc_in = '0;
         cnt_in = '0;
      end
   end

   assign queue_wr.push        = nbytes != 2'd0;
   assign queue_wr.job.word    = word;
   assign queue_wr.job.nbytes  = nbytes;
   assign queue_wr.job.msg_end = req.msg_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.msg_last |=> cnt_ff == 2'd0)
      else $error("sextet count not cleared after end of message");
`endif

endmodule

`default_nettype wire

>>> rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// Base64 decoder group queue
// Short first-in first-out store of decoded groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue #(
   parameter int unsigned DEPTH = b64d_pkg::QueueDepthDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire b64d_pkg::queue_wr_type  queue_wr,
   output logic                         queue_space,
   output b64d_pkg::queue_head_type     queue_head,
   input  wire logic                    pop
);
   import b64d_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   job_type        mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign queue_space = count_ff != CW'(DEPTH);
   assign do_push     = queue_wr.push;
   assign do_pop      = pop && count_ff != '0;

   assign queue_head.valid = count_ff != '0;
   assign queue_head.job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= queue_wr.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      do_push |-> count_ff != CW'(DEPTH))
      else $error("group pushed into a full queue");
`endif

endmodule

`default_nettype wire

>>> rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// Base64 decoder back
// Splits queued groups into bytes and drives the registered output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire b64d_pkg::queue_head_type queue_head,
   output logic                          pop,
   b64d_rsp_if.source                    rsp
);
   import b64d_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   byte_type   data_ff, data_in;
   logic       run_last_ff, run_last_in;
   logic       msg_end_ff, msg_end_in;
   logic       step;
   logic       final_byte;

   assign step       = queue_head.valid && (!valid_ff || rsp.ready);
   assign final_byte = idx_ff == queue_head.job.nbytes - 2'd1;
   assign pop        = step && final_byte;

   always_comb begin
      idx_in      = idx_ff;
      valid_in    = valid_ff && !rsp.ready;
      data_in     = data_ff;
      run_last_in = run_last_ff;
      msg_end_in  = msg_end_ff;
      if (step) begin
         valid_in    = 1'b1;
         run_last_in = final_byte;
         msg_end_in  = final_byte && queue_head.job.msg_end;
         idx_in      = final_byte ? 2'd0 : idx_ff + 2'd1;
         case (idx_ff)
            2'd0:    data_in = queue_head.job.word[23:16];
            2'd1:    data_in = queue_head.job.word[15:8];
            default: data_in = queue_head.job.word[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      data_ff     <= data_in;
      run_last_ff <= run_last_in;
      msg_end_ff  <= msg_end_in;
   end

   assign rsp.valid     = valid_ff;
   assign rsp.data_byte = data_ff;
   assign rsp.run_last  = run_last_ff;
   assign rsp.msg_end   = msg_end_ff;

`ifndef SYNTHESIS
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      queue_head.valid |-> idx_ff < queue_head.job.nbytes)
      else $error("byte index runs past the queued group");

   a_no_empty_group: assert property (@(posedge clock) disable iff (reset)
      queue_head.valid |-> queue_head.job.nbytes != 2'd0)
      else $error("queued group carries no bytes");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && msg_end_ff |-> run_last_ff)
      else $error("message end flagged on a byte that is not the last of its run");
`endif

endmodule

`default_nettype wire

>>> rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes a base64 character stream into bytes, one character per word.
// ----------------------------------------------------------------------------
// The req_chan channel takes one raw character per word, with msg_last set on
// the final character of a message. Letters, digits, '+' and '/' are decoded;
// every other byte, including '=' padding and line breaks, is dropped.
// The rsp_chan channel delivers decoded bytes one per word. run_last marks the
// last byte caused by one input character, and msg_end marks the final byte
// of a message. A message that ends with two or three pending sextets yields
// one or two bytes; with fewer pending sextets it yields nothing.
// A character is taken every cycle while the group queue has room. The first
// byte of a group goes through the group queue into the output register once
// the character completing it is accepted, and bytes leave at one per cycle
// while the receiver is ready, so the sustained rate is one character per
// cycle when the receiver does not stall.
// When the receiver stalls, finished groups collect in the queue (QUEUE_DEPTH
// groups) and req_chan.ready drops only once the queue is full.
// Reset is synchronous and clears the pending sextets, the queue and the
// output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder #(
   parameter int unsigned QUEUE_DEPTH = b64d_pkg::QueueDepthDefault
) (
   input  wire logic   clock,
   input  wire logic   reset,
   b64d_req_if.sink    req_chan,
   b64d_rsp_if.source  rsp_chan
);
   import b64d_pkg::*;

   queue_wr_type   queue_wr;
   queue_head_type queue_head;
   logic           queue_space;
   logic           pop;

   // The front maps characters to sextets and emits whole groups.
   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .queue_space (queue_space),
      .queue_wr    (queue_wr)
   );

   // The queue decouples character intake from byte delivery.
   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .queue_wr    (queue_wr),
      .queue_space (queue_space),
      .queue_head  (queue_head),
      .pop         (pop)
   );

   // The back sends each group out as one to three bytes.
   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_head (queue_head),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

`default_nettype wire

>>> sim/tb_base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Sends directed and random character streams into the decoder and checks
// every decoded byte and its flags against a behavioral prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_base64_stream_decoder;

   import b64d_pkg::*;

   // Characters used by the stimulus that the alphabet constants do not cover.
   localparam byte_type CharPad     = 8'h3d;  // '='
   localparam byte_type CharNewline = 8'h0a;
   localparam byte_type CharNul     = 8'h00;
   localparam byte_type CharAt      = 8'h40;  // just below 'A'
   localparam byte_type CharBracket = 8'h5b;  // just above 'Z'
   localparam byte_type CharTick    = 8'h60;  // just below 'a'
   localparam byte_type CharBrace   = 8'h7b;  // just above 'z'
   localparam byte_type CharColon   = 8'h3a;  // just above '9'
   localparam byte_type CharTop     = 8'hff;
   localparam byte_type CharHigh    = 8'h80;

   // The receiver holds off for this many cycles at two points of the run.
   localparam int unsigned HoldCycles  = 60;
   localparam int unsigned FirstHold   = 30;
   localparam int unsigned SecondHold  = 110;
   localparam int unsigned RandomChars = 205;

   // One character word as the sender offers it.
   typedef struct packed {
      byte_type enc_char;
      logic     msg_last;
   } char_word_type;

   // One decoded byte word as the receiver should see it.
   typedef struct packed {
      byte_type data_byte;
      logic     run_last;
      logic     msg_end;
   } byte_word_type;

   // Result of the alphabet lookup: known is low for a skipped character.
   typedef struct packed {
      logic       known;
      logic [5:0] value;
   } lookup_type;

   logic clock;
   logic reset;

   b64d_req_if req_chan ();
   b64d_rsp_if rsp_chan ();

   base64_stream_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Characters waiting to be offered, and bytes that the decoder still owes.
   char_word_type  char_queue[$];
   byte_word_type  expected_bytes[$];

   // Predicted decoder state: pending sextets, newest in the low six bits.
   acc_type     pending_bits;
   logic [1:0]  pending_count;

   int unsigned total_chars;
   int unsigned chars_taken;
   int unsigned bytes_seen;
   int unsigned error_count;

   // Sender and receiver pacing.  A calm side draws no random gaps, so the run
   // mixes stretches at full rate with stretches full of gaps.
   int unsigned    send_wait;
   int unsigned    recv_wait;
   int unsigned    hold_left;
   logic           send_calm;
   logic           recv_calm;
   char_word_type  next_char;
   byte_word_type  want;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Looks a raw character up in the base64 alphabet.
   function automatic lookup_type sextet_of(input byte_type c);
      lookup_type s;
      s = '0;
      if (c >= CharUpperA && c <= CharUpperZ) begin
         s.known = 1'b1;
         s.value = 6'(c - CharUpperA);
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
         s.known = 1'b1;
         s.value = 6'(c - CharLowerA + 8'd26);
      end else if (c >= CharDigit0 && c <= CharDigit9) begin
         s.known = 1'b1;
         s.value = 6'(c - CharDigit0 + 8'd52);
      end else if (c == CharPlus) begin
         s.known = 1'b1;
         s.value = 6'd62;
      end else if (c == CharSlash) begin
         s.known = 1'b1;
         s.value = 6'd63;
      end
      return s;
   endfunction

   // Advances the predicted state by one accepted character and queues the
   // bytes that it releases.  A fourth sextet completes a group of three
   // bytes; the end of a message flushes two or three pending sextets as one
   // or two bytes, with the missing sextets taken as zero, and always leaves
   // the state empty.
   function automatic void decode_char(input byte_type c, input logic last);
      lookup_type     s;
      group_type      grp;
      int unsigned    n_out;
      byte_word_type  w;
      s     = sextet_of(c);
      grp   = '0;
      n_out = 0;
      if (s.known) begin
         if (pending_count == 2'd3) begin
            grp           = {pending_bits, s.value};
            n_out         = 3;
            pending_bits  = '0;
            pending_count = '0;
         end else begin
            pending_bits  = {pending_bits[11:0], s.value};
            pending_count = pending_count + 2'd1;
         end
      end
      if (last) begin
         if (n_out == 0 && pending_count >= 2'd2) begin
            grp   = group_type'(pending_bits) << (6 * (4 - int'(pending_count)));
            n_out = int'(pending_count) - 1;
         end
         pending_bits  = '0;
         pending_count = '0;
      end
      for (int unsigned k = 0; k < n_out; k++) begin
         w.data_byte = grp[23 - 8 * k -: 8];
         w.run_last  = (k == n_out - 1);
         w.msg_end   = w.run_last && last;
         expected_bytes.push_back(w);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   task automatic add_char(input byte_type c, input logic last);
      char_word_type w;
      w.enc_char = c;
      w.msg_last = last;
      char_queue.push_back(w);
   endtask

   function automatic byte_type alphabet_char(input int unsigned v);
      if (v < 26) return CharUpperA + byte_type'(v);
      if (v < 52) return CharLowerA + byte_type'(v - 26);
      if (v < 62) return CharDigit0 + byte_type'(v - 52);
      if (v == 62) return CharPlus;
      return CharSlash;
   endfunction

   // Any byte outside the alphabet, drawn from the whole byte range.
   function automatic byte_type noise_char();
      byte_type   c;
      lookup_type s;
      c = byte_type'($urandom_range(0, 255));
      s = sextet_of(c);
      while (s.known) begin
         c = byte_type'($urandom_range(0, 255));
         s = sextet_of(c);
      end
      return c;
   endfunction

   // Queues one message.  Most messages are proper base64 text with a few
   // stray characters mixed in, and they end in one of several ways: on the
   // last sextet, on '=' padding, on a line break or on some other skipped
   // byte.  The sextet count covers every remainder modulo four, so groups
   // that end short by one, two or three sextets all occur.  About one
   // message in eight is raw noise with the last flag set at random.
   task automatic queue_message();
      int unsigned n_sextets;
      int unsigned tail;
      int unsigned pads;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 8))
            add_char(byte_type'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
         n_sextets = $urandom_range(0, 14);
         tail      = (n_sextets == 0) ? 3 : $urandom_range(0, 3);
         for (int unsigned k = 0; k < n_sextets; k++) begin
            if ($urandom_range(0, 9) == 0) add_char(noise_char(), 1'b0);
            add_char(alphabet_char($urandom_range(0, 63)), tail == 0 && k == n_sextets - 1);
         end
         case (tail)
            1: begin
               pads = (4 - n_sextets % 4) % 4;
               if (pads == 0) begin
                  add_char(CharPad, 1'b1);
               end else begin
                  for (int unsigned p = 0; p < pads; p++) add_char(CharPad, p == pads - 1);
               end
            end
            2: add_char(CharNewline, 1'b1);
            3: add_char(noise_char(), 1'b1);
            default: ;
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers the queued characters on req_chan.  A word that is not
   // taken stays on the bus unchanged; after each accepted word the sender
   // draws a random gap unless it is in a calm stretch.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_wait = 0;
         send_calm = 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            decode_char(req_chan.enc_char, req_chan.msg_last);
            chars_taken++;
            if (chars_taken % 32 == 0) send_calm = 1'($urandom_range(0, 1));
            send_wait = send_calm ? 0 : $urandom_range(0, 9);
         end
         // A stalled word holds; otherwise the sender idles or moves on.
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (send_wait > 0) begin
               send_wait--;
               req_chan.valid <= 1'b0;
            end else if (char_queue.size() > 0) begin
               next_char = char_queue.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.enc_char <= next_char.enc_char;
               req_chan.msg_last <= next_char.msg_last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: takes decoded bytes from rsp_chan and compares each one with
   // the oldest expected byte.  The receiver draws its own stall after each
   // word, and twice it holds off for a long stretch while the sender keeps
   // offering, so the group queue inside the decoder fills and req_chan
   // backs up.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_wait = 0;
         hold_left = 0;
         recv_calm = 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected word: data_byte %0h run_last %0b msg_end %0b",
                      rsp_chan.data_byte, rsp_chan.run_last, rsp_chan.msg_end);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_chan.data_byte !== want.data_byte) begin
                  $error("data_byte: expected %0h, got %0h", want.data_byte,
                         rsp_chan.data_byte);
                  error_count++;
               end
               if (rsp_chan.run_last !== want.run_last) begin
                  $error("run_last: expected %0b, got %0b", want.run_last, rsp_chan.run_last);
                  error_count++;
               end
               if (rsp_chan.msg_end !== want.msg_end) begin
                  $error("msg_end: expected %0b, got %0b", want.msg_end, rsp_chan.msg_end);
                  error_count++;
               end
            end
            bytes_seen++;
            if (bytes_seen == FirstHold || bytes_seen == SecondHold) hold_left = HoldCycles;
            if (bytes_seen % 24 == 0) recv_calm = 1'($urandom_range(0, 1));
            recv_wait = recv_calm ? 0 : $urandom_range(0, 9);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.enc_char = '0;
      req_chan.msg_last = 1'b0;
      rsp_chan.ready    = 1'b0;
      pending_bits      = '0;
      pending_count     = '0;
      chars_taken       = 0;
      bytes_seen        = 0;
      error_count       = 0;

      // Directed part.  A full group in mid message built from the range
      // edges, with the characters just outside the ranges dropped.
      add_char(CharUpperA, 1'b0);
      add_char(CharAt, 1'b0);
      add_char(CharUpperZ, 1'b0);
      add_char(CharBracket, 1'b0);
      add_char(CharLowerA, 1'b0);
      add_char(CharLowerZ, 1'b0);
      // A message whose last character completes a group.
      add_char(CharDigit0, 1'b0);
      add_char(CharColon, 1'b0);
      add_char(CharDigit9, 1'b0);
      add_char(CharPlus, 1'b0);
      add_char(CharSlash, 1'b1);
      // Two pending sextets flushed by padding, the last flag on a skipped byte.
      add_char(CharNul, 1'b0);
      add_char(CharTop, 1'b0);
      add_char(alphabet_char(16), 1'b0);
      add_char(alphabet_char(16), 1'b0);
      add_char(CharPad, 1'b0);
      add_char(CharPad, 1'b1);
      // Three pending sextets flushed by a line break.
      add_char(CharLowerZ - 8'd2, 1'b0);
      add_char(CharTick, 1'b0);
      add_char(CharLowerZ - 8'd1, 1'b0);
      add_char(CharBrace, 1'b0);
      add_char(CharLowerZ, 1'b0);
      add_char(CharNewline, 1'b1);
      // A message of one sextet and an empty message yield nothing.
      add_char(CharUpperA, 1'b1);
      add_char(CharHigh, 1'b1);
      // Two pending sextets ended on a valid character.
      add_char(alphabet_char(16), 1'b0);
      add_char(alphabet_char(17), 1'b1);

      while (char_queue.size() < 26 + RandomChars) queue_message();
      total_chars = char_queue.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Sampled on the falling edge, where every update of the rising edge
      // has settled.
      while (chars_taken != total_chars || expected_bytes.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog for a decoder that hangs or loses words.
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
